@@ hw/rtl/rc4_pkg.sv @@
// rc4_pkg: shared constants, control word type and microcode program for the RC4 engine.
// Depends on nothing; used by rc4_useq, rc4_stream_cipher and the testbench.
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int MAX_KEY_BYTES_DEF = 256;
    localparam logic [8:0] KEY_LEN_RESET = 9'd16;

    localparam logic [1:0] CMD_LOAD     = 2'd0;
    localparam logic [1:0] CMD_SCHEDULE = 2'd1;
    localparam logic [1:0] CMD_CRYPT    = 2'd2;

    localparam int UPC_W = 5;

    // microcode entry points and steps
    localparam logic [UPC_W-1:0] U_IDLE  = 5'd0;
    localparam logic [UPC_W-1:0] U_RFILL = 5'd1;
    localparam logic [UPC_W-1:0] U_RDONE = 5'd2;
    localparam logic [UPC_W-1:0] U_LOAD  = 5'd3;
    localparam logic [UPC_W-1:0] U_NOP   = 5'd4;
    localparam logic [UPC_W-1:0] U_SCHED = 5'd5;
    localparam logic [UPC_W-1:0] K_A     = 5'd6;
    localparam logic [UPC_W-1:0] K_B     = 5'd7;
    localparam logic [UPC_W-1:0] K_C     = 5'd8;
    localparam logic [UPC_W-1:0] K_D     = 5'd9;
    localparam logic [UPC_W-1:0] K_E     = 5'd10;
    localparam logic [UPC_W-1:0] K_END   = 5'd11;
    localparam logic [UPC_W-1:0] C_1     = 5'd12;
    localparam logic [UPC_W-1:0] C_2     = 5'd13;
    localparam logic [UPC_W-1:0] C_3     = 5'd14;
    localparam logic [UPC_W-1:0] C_4     = 5'd15;
    localparam logic [UPC_W-1:0] C_5     = 5'd16;
    localparam logic [UPC_W-1:0] C_6     = 5'd17;
    localparam logic [UPC_W-1:0] C_7     = 5'd18;

    typedef enum logic [1:0] {SEQ_NEXT, SEQ_JUMP, SEQ_LOOP, SEQ_DISPATCH} t_seq_op;
    typedef enum logic [2:0] {RA_CNT, RA_ACC, RA_IA1, RA_IB, RA_SUM} t_raddr;
    typedef enum logic [1:0] {WA_CNT, WA_ACC, WA_IA, WA_IB} t_waddr;
    typedef enum logic [1:0] {WD_CNT, WD_RD, WD_SI} t_wdata;
    typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC} t_cnt_op;
    typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_KSA} t_acc_op;
    typedef enum logic [1:0] {IA_HOLD, IA_CLR, IA_INC} t_ia_op;
    typedef enum logic [1:0] {IB_HOLD, IB_CLR, IB_ADD} t_ib_op;
    typedef enum logic [1:0] {KP_HOLD, KP_CLR, KP_ADV} t_kp_op;
    typedef enum logic [1:0] {PTR_HOLD, PTR_CLR, PTR_LOAD} t_ptr_op;
    typedef enum logic [1:0] {OUT_NONE, OUT_ACK, OUT_DATA} t_out_op;

    typedef struct packed {
        t_seq_op          seq;
        logic [UPC_W-1:0] target;
        logic             s_re;
        t_raddr           raddr;
        logic             s_we;
        t_waddr           waddr;
        t_wdata           wdata;
        logic             k_re;
        t_cnt_op          cnt_op;
        t_acc_op          acc_op;
        t_ia_op           ia_op;
        t_ib_op           ib_op;
        t_kp_op           kp_op;
        t_ptr_op          ptr_op;
        logic             si_ld;
        logic             sj_ld;
        t_out_op          out_op;
    } t_cw;

    typedef struct packed {
        logic       start;
        logic [1:0] cmd;
        logic       cnt_last;
    } t_seq_status;

    function automatic t_cw ucode_rom(input logic [UPC_W-1:0] addr);
        t_cw cw;
        cw = '0;
        cw.seq = SEQ_JUMP;
        cw.target = U_IDLE;
        case (addr)
            U_IDLE: begin
                cw.seq = SEQ_DISPATCH;
            end
            // reset pass: identity fill, no result
            U_RFILL: begin
                cw.s_we = 1'b1; cw.waddr = WA_CNT; cw.wdata = WD_CNT;
                cw.cnt_op = CNT_INC; cw.seq = SEQ_LOOP; cw.target = U_RFILL;
            end
            U_RDONE: begin
                cw.seq = SEQ_JUMP;
            end
            U_LOAD: begin
                cw.ptr_op = PTR_LOAD; cw.out_op = OUT_ACK;
            end
            U_NOP: begin
                cw.out_op = OUT_ACK;
            end
            U_SCHED: begin
                cw.s_we = 1'b1; cw.waddr = WA_CNT; cw.wdata = WD_CNT;
                cw.cnt_op = CNT_INC; cw.ia_op = IA_CLR; cw.ib_op = IB_CLR;
                cw.acc_op = ACC_CLR; cw.kp_op = KP_CLR;
                cw.seq = SEQ_LOOP; cw.target = U_SCHED;
            end
            K_A: begin
                cw.s_re = 1'b1; cw.raddr = RA_CNT; cw.k_re = 1'b1; cw.seq = SEQ_NEXT;
            end
            K_B: begin
                cw.si_ld = 1'b1; cw.acc_op = ACC_KSA; cw.seq = SEQ_NEXT;
            end
            K_C: begin
                cw.s_re = 1'b1; cw.raddr = RA_ACC; cw.seq = SEQ_NEXT;
            end
            K_D: begin
                cw.s_we = 1'b1; cw.waddr = WA_CNT; cw.wdata = WD_RD; cw.seq = SEQ_NEXT;
            end
            K_E: begin
                cw.s_we = 1'b1; cw.waddr = WA_ACC; cw.wdata = WD_SI;
                cw.cnt_op = CNT_INC; cw.kp_op = KP_ADV;
                cw.seq = SEQ_LOOP; cw.target = K_A;
            end
            K_END: begin
                cw.ptr_op = PTR_CLR; cw.out_op = OUT_ACK;
            end
            C_1: begin
                cw.s_re = 1'b1; cw.raddr = RA_IA1; cw.ia_op = IA_INC; cw.seq = SEQ_NEXT;
            end
            C_2: begin
                cw.si_ld = 1'b1; cw.ib_op = IB_ADD; cw.seq = SEQ_NEXT;
            end
            C_3: begin
                cw.s_re = 1'b1; cw.raddr = RA_IB; cw.seq = SEQ_NEXT;
            end
            C_4: begin
                cw.s_we = 1'b1; cw.waddr = WA_IA; cw.wdata = WD_RD;
                cw.sj_ld = 1'b1; cw.seq = SEQ_NEXT;
            end
            C_5: begin
                cw.s_we = 1'b1; cw.waddr = WA_IB; cw.wdata = WD_SI; cw.seq = SEQ_NEXT;
            end
            C_6: begin
                cw.s_re = 1'b1; cw.raddr = RA_SUM; cw.seq = SEQ_NEXT;
            end
            C_7: begin
                cw.out_op = OUT_DATA;
            end
            default: begin
                cw.seq = SEQ_JUMP;
            end
        endcase
        return cw;
    endfunction

endpackage

@@ hw/rtl/rc4_useq.sv @@
// rc4_useq: micro-program counter, microcode table lookup and jump logic.
// Depends on rc4_pkg for the control word, status struct and program.
`timescale 1ns / 1ps

module rc4_useq
    import rc4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_seq_status i_status,
    output t_cw         o_cw,
    output logic        o_busy
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_cw              w_cw;

    assign w_cw   = ucode_rom(r_upc);
    assign o_cw   = w_cw;
    assign o_busy = (r_upc != U_IDLE);

    always_comb begin
        n_upc = r_upc;
        unique case (w_cw.seq)
            SEQ_NEXT: n_upc = r_upc + UPC_W'(1);
            SEQ_JUMP: n_upc = w_cw.target;
            SEQ_LOOP: n_upc = i_status.cnt_last ? r_upc + UPC_W'(1) : w_cw.target;
            SEQ_DISPATCH: begin
                if (i_status.start) begin
                    unique case (i_status.cmd)
                        CMD_LOAD:     n_upc = U_LOAD;
                        CMD_SCHEDULE: n_upc = U_SCHED;
                        CMD_CRYPT:    n_upc = C_1;
                        default:      n_upc = U_NOP;
                    endcase
                end
            end
            default: n_upc = U_IDLE;
        endcase
    end

    // reset enters the identity fill pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_RFILL;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

@@ hw/rtl/rc4_stream_cipher.sv @@
// rc4_stream_cipher: RC4 engine top level, datapath, permutation and key memories.
// Depends on rc4_pkg and rc4_useq.
//
// Channel   Direction  Handshake                      Payload
// command   in         start high, busy low           i_cmd, i_data_byte
// result    out        o_res_valid, one-cycle strobe  o_out_byte, o_is_data
// config    in         i_cfg_valid and o_cfg_ready    i_cfg_data (key byte count)
//
// A schedule transaction makes 256 identity writes, then runs 5 steps per key-scheduling round.
// After reset, busy stays high while the permutation is filled with identity. The result strobe
// lands in the cycle busy drops, so a new command can be taken while it is shown; results cannot
// be stalled.
`timescale 1ns / 1ps

module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data_byte,
    output logic       o_res_valid,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data
);

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KPW    = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [KPW-1:0] PTR_FULL = KPW'(MAX_KEY_BYTES);
    localparam logic [8:0]     LEN_MAX  = 9'(MAX_KEY_BYTES);

    t_cw         w_cw;
    t_seq_status w_status;
    logic        w_accept;

    logic [7:0]        r_perm [256];
    logic [7:0]        r_kmem [MAX_KEY_BYTES];
    logic [7:0]        r_rd;
    logic [7:0]        r_krd;
    logic [7:0]        r_cnt;
    logic [7:0]        r_acc;
    logic [7:0]        r_ia;
    logic [7:0]        r_ib;
    logic [7:0]        r_si;
    logic [7:0]        r_sj;
    logic [KEY_AW-1:0] r_kpos;
    logic [KPW-1:0]    r_key_ptr;
    logic [8:0]        r_key_len;
    logic [7:0]        r_data;
    logic              r_res_valid;
    logic [7:0]        r_out_byte;
    logic              r_is_data;

    logic [7:0] w_raddr;
    logic [7:0] w_waddr;
    logic [7:0] w_wdata;
    logic [8:0] w_len;
    logic [8:0] w_kpos_inc;
    logic       w_key_we;

    assign w_accept = start && !busy;
    assign w_status = '{start: start, cmd: i_cmd, cnt_last: (r_cnt == 8'hFF)};

    rc4_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cw     (w_cw),
        .o_busy   (busy)
    );

    always_comb begin
        case (w_cw.raddr)
            RA_CNT:  w_raddr = r_cnt;
            RA_ACC:  w_raddr = r_acc;
            RA_IA1:  w_raddr = r_ia + 8'd1;
            RA_IB:   w_raddr = r_ib;
            RA_SUM:  w_raddr = r_si + r_sj;
            default: w_raddr = r_cnt;
        endcase
        case (w_cw.waddr)
            WA_CNT:  w_waddr = r_cnt;
            WA_ACC:  w_waddr = r_acc;
            WA_IA:   w_waddr = r_ia;
            WA_IB:   w_waddr = r_ib;
            default: w_waddr = r_cnt;
        endcase
        case (w_cw.wdata)
            WD_CNT:  w_wdata = r_cnt;
            WD_RD:   w_wdata = r_rd;
            WD_SI:   w_wdata = r_si;
            default: w_wdata = r_cnt;
        endcase
    end

    // zero length counts as one, oversize saturates to the key store depth
    always_comb begin
        w_len = r_key_len;
        if (r_key_len == 9'd0) begin
            w_len = 9'd1;
        end else if (r_key_len > LEN_MAX) begin
            w_len = LEN_MAX;
        end
    end

    assign w_kpos_inc = 9'(r_kpos) + 9'd1;
    assign w_key_we   = (w_cw.ptr_op == PTR_LOAD) && (r_key_ptr < PTR_FULL);

    always_ff @(posedge i_clk) begin
        if (w_cw.s_we) begin
            r_perm[w_waddr] <= w_wdata;
        end
        if (w_cw.s_re) begin
            r_rd <= r_perm[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_kmem[r_key_ptr[KEY_AW-1:0]] <= r_data;
        end
        if (w_cw.k_re) begin
            r_krd <= r_kmem[r_kpos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_acc       <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_kpos      <= '0;
            r_key_ptr   <= '0;
            r_key_len   <= KEY_LEN_RESET;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_key_len <= i_cfg_data;
            end
            case (w_cw.cnt_op)
                CNT_CLR: r_cnt <= '0;
                CNT_INC: r_cnt <= r_cnt + 8'd1;
                default: r_cnt <= r_cnt;
            endcase
            case (w_cw.acc_op)
                ACC_CLR: r_acc <= '0;
                ACC_KSA: r_acc <= r_acc + r_rd + r_krd;
                default: r_acc <= r_acc;
            endcase
            case (w_cw.ia_op)
                IA_CLR:  r_ia <= '0;
                IA_INC:  r_ia <= r_ia + 8'd1;
                default: r_ia <= r_ia;
            endcase
            case (w_cw.ib_op)
                IB_CLR:  r_ib <= '0;
                IB_ADD:  r_ib <= r_ib + r_rd;
                default: r_ib <= r_ib;
            endcase
            // wrap the key position at the effective length
            case (w_cw.kp_op)
                KP_CLR:  r_kpos <= '0;
                KP_ADV:  r_kpos <= (w_kpos_inc >= w_len) ? '0 : KEY_AW'(w_kpos_inc);
                default: r_kpos <= r_kpos;
            endcase
            case (w_cw.ptr_op)
                PTR_CLR:  r_key_ptr <= '0;
                PTR_LOAD: begin
                    if (w_key_we) begin
                        r_key_ptr <= r_key_ptr + KPW'(1);
                    end
                end
                default:  r_key_ptr <= r_key_ptr;
            endcase
            r_res_valid <= (w_cw.out_op == OUT_ACK) || (w_cw.out_op == OUT_DATA);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_data_byte;
        end
        if (w_cw.si_ld) begin
            r_si <= r_rd;
        end
        if (w_cw.sj_ld) begin
            r_sj <= r_rd;
        end
        case (w_cw.out_op)
            OUT_ACK: begin
                r_out_byte <= 8'd0;
                r_is_data  <= 1'b0;
            end
            OUT_DATA: begin
                r_out_byte <= r_data ^ r_rd;
                r_is_data  <= 1'b1;
            end
            default: begin
                r_out_byte <= r_out_byte;
                r_is_data  <= r_is_data;
            end
        endcase
    end

    assign o_res_valid = r_res_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_data   = r_is_data;
    assign o_cfg_ready = 1'b1;

`ifndef ASSERT_OFF
    a_res_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result strobe while sequencer busy");

    a_res_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result strobe without a finished transaction");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted transaction did not start the sequencer");

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_is_data) |-> (o_out_byte == 8'd0))
        else $error("acknowledgement carries nonzero byte");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_ptr <= PTR_FULL)
        else $error("key load pointer beyond key store");
`endif

endmodule

@@ tb/rc4_stream_cipher_tb.sv @@
// rc4_stream_cipher_tb: self-checking testbench for the RC4 engine with a built-in
// RC4 predictor and a scoreboard of expected result bytes.
// Depends on rc4_pkg and rc4_stream_cipher.
`timescale 1ns / 1ps

module rc4_stream_cipher_tb
    import rc4_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1250;
    localparam int TOTAL_ITEMS = 1350;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
    } t_rc4_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_cmd;
    logic [7:0] i_data_byte;
    logic       o_res_valid;
    logic [7:0] o_out_byte;
    logic       o_is_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [8:0] i_cfg_data;

    // predictor state
    logic [7:0] sbox [256];
    logic [7:0] key_bytes [256];
    logic [8:0] key_wr_ptr;
    logic [7:0] ks_i;
    logic [7:0] ks_j;
    logic [8:0] key_len_cfg;
    int         key_filled;

    t_rc4_result expected_q [$];
    int          mismatch_cnt;
    int          items_sent;
    bit          idle_en;

    rc4_stream_cipher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .o_res_valid (o_res_valid),
        .o_out_byte  (o_out_byte),
        .o_is_data   (o_is_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic int eff_key_len();
        if (key_len_cfg == 9'd0) begin
            return 1;
        end
        if (key_len_cfg > MAX_KEY_BYTES_DEF) begin
            return MAX_KEY_BYTES_DEF;
        end
        return int'(key_len_cfg);
    endfunction

    function automatic void rc4_rekey();
        int         len;
        int         kpos;
        logic [7:0] acc;
        logic [7:0] tmp;
        len = eff_key_len();
        kpos = 0;
        acc = 8'd0;
        for (int k = 0; k < 256; k++) begin
            sbox[k] = k[7:0];
        end
        ks_i = 8'd0;
        ks_j = 8'd0;
        for (int k = 0; k < 256; k++) begin
            acc = acc + sbox[k] + key_bytes[kpos];
            tmp = sbox[k];
            sbox[k] = sbox[acc];
            sbox[acc] = tmp;
            kpos++;
            if (kpos >= len) begin
                kpos = 0;
            end
        end
        key_wr_ptr = 9'd0;
    endfunction

    function automatic t_rc4_result rc4_predict(input logic [1:0] cmd, input logic [7:0] data);
        t_rc4_result res;
        logic [7:0]  tmp;
        logic [7:0]  sum;
        res = '0;
        case (cmd)
            CMD_LOAD: begin
                // a full store drops the byte but still acknowledges
                if (key_wr_ptr < MAX_KEY_BYTES_DEF) begin
                    key_bytes[key_wr_ptr[7:0]] = data;
                    key_wr_ptr = key_wr_ptr + 9'd1;
                end
            end
            CMD_SCHEDULE: begin
                rc4_rekey();
            end
            CMD_CRYPT: begin
                ks_i = ks_i + 8'd1;
                ks_j = ks_j + sbox[ks_i];
                tmp = sbox[ks_i];
                sbox[ks_i] = sbox[ks_j];
                sbox[ks_j] = tmp;
                sum = sbox[ks_i] + sbox[ks_j];
                res.out_byte = data ^ sbox[sum];
                res.is_data = 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        if (mismatch_cnt < SHOWN_MISMATCHES) begin
            $display("[%0t] error: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    // scoreboard: every strobed result is matched against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_rc4_result exp_r;
        if (i_rst_n && o_res_valid) begin
            if (expected_q.size() == 0) begin
                log_mismatch($sformatf("result with nothing pending: out_byte=%02h is_data=%0b",
                                       o_out_byte, o_is_data));
            end else begin
                exp_r = expected_q.pop_front();
                if (o_out_byte !== exp_r.out_byte) begin
                    log_mismatch($sformatf("out_byte expected %02h got %02h",
                                           exp_r.out_byte, o_out_byte));
                end
                if (o_is_data !== exp_r.is_data) begin
                    log_mismatch($sformatf("is_data expected %0b got %0b",
                                           exp_r.is_data, o_is_data));
                end
            end
        end
    end

    // start stays high after the transaction; the next call or release_cmd decides
    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data);
        int unsigned gap;
        bit          counted;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_data_byte <= data;
        do @(posedge i_clk); while (busy);
        counted = !(cmd == CMD_UNUSED || (cmd == CMD_LOAD && key_wr_ptr >= MAX_KEY_BYTES_DEF));
        expected_q.push_back(rc4_predict(cmd, data));
        if (int'(key_wr_ptr) > key_filled) begin
            key_filled = int'(key_wr_ptr);
        end
        if (counted) begin
            items_sent++;
        end
    endtask

    task automatic release_cmd();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // hold until every result is in and the engine is idle
    task automatic drain();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_key_len(input logic [8:0] len);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 1) == 0) begin
            gap = $urandom_range(1, 13);
            repeat (gap) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        key_len_cfg = len;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_crypts(input int count);
        for (int n = 0; n < count; n++) begin
            send_cmd(CMD_CRYPT, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_directed();
        // crypt on the identity permutation left by reset
        send_cmd(CMD_CRYPT, 8'h00);
        send_cmd(CMD_CRYPT, 8'hFF);
        send_cmd(CMD_CRYPT, 8'h5A);
        send_cmd(CMD_UNUSED, 8'hFF);
        release_cmd();
        drain();
        // zero length acts as a single key byte
        write_key_len(9'd0);
        send_cmd(CMD_LOAD, 8'hFF);
        send_cmd(CMD_LOAD, 8'h00);
        send_cmd(CMD_SCHEDULE, 8'hFF);
        send_cmd(CMD_CRYPT, 8'h00);
        send_cmd(CMD_CRYPT, 8'hFF);
        send_cmd(CMD_CRYPT, 8'h3C);
        send_cmd(CMD_UNUSED, 8'h00);
        send_cmd(CMD_SCHEDULE, 8'h00);
        send_cmd(CMD_CRYPT, 8'hC3);
        release_cmd();
        drain();
        write_key_len(9'd2);
        send_cmd(CMD_LOAD, 8'h80);
        send_cmd(CMD_LOAD, 8'h7F);
        send_cmd(CMD_SCHEDULE, 8'h55);
        send_cmd(CMD_CRYPT, 8'hAA);
        send_cmd(CMD_CRYPT, 8'h01);
        release_cmd();
        drain();
    endtask

    task automatic test_key_store_full();
        write_key_len(9'd256);
        for (int n = 0; n < 256; n++) begin
            send_cmd(CMD_LOAD, 8'($urandom_range(0, 255)));
        end
        // store is full: these are dropped
        send_cmd(CMD_LOAD, 8'hFF);
        send_cmd(CMD_LOAD, 8'h00);
        send_cmd(CMD_SCHEDULE, 8'h00);
        send_random_crypts(16);
        release_cmd();
        drain();
        // lengths past the store size saturate
        write_key_len(9'd511);
        send_cmd(CMD_SCHEDULE, 8'hFF);
        send_random_crypts(8);
        release_cmd();
        drain();
        write_key_len(9'd257);
        send_cmd(CMD_SCHEDULE, 8'h00);
        send_random_crypts(8);
        release_cmd();
        drain();
    endtask

    // one rekey session: set length, load key, schedule once enough key is loaded, then mostly crypt traffic
    task automatic run_session();
        int unsigned pick;
        logic [8:0]  len;
        logic [1:0]  cmd;
        int          nloads;
        int          body;
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            len = 9'd0;
        end else if (pick < 6) begin
            len = 9'($urandom_range(257, 511));
        end else if (pick < 12) begin
            len = 9'($urandom_range(17, 256));
        end else begin
            len = 9'($urandom_range(1, 16));
        end
        write_key_len(len);
        nloads = eff_key_len();
        if ($urandom_range(0, 4) == 0) begin
            nloads = $urandom_range(0, nloads + 3);
        end
        for (int n = 0; n < nloads; n++) begin
            send_cmd(CMD_LOAD, 8'($urandom_range(0, 255)));
        end
        if (key_filled >= eff_key_len()) begin
            send_cmd(CMD_SCHEDULE, 8'($urandom_range(0, 255)));
        end
        body = $urandom_range(8, 48);
        for (int n = 0; n < body; n++) begin
            cmd = CMD_CRYPT;
            if ($urandom_range(0, 99) < 15) begin
                cmd = 2'($urandom_range(0, 3));
                if (cmd == CMD_SCHEDULE && key_filled < eff_key_len()) begin
                    cmd = CMD_CRYPT;
                end
            end
            send_cmd(cmd, 8'($urandom_range(0, 255)));
        end
        release_cmd();
        drain();
    endtask

    task automatic test_random_traffic(input int target);
        while (items_sent < target) begin
            run_session();
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cmd <= CMD_LOAD;
        i_data_byte <= 8'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 9'd0;
        for (int k = 0; k < 256; k++) begin
            sbox[k] = k[7:0];
            key_bytes[k] = 8'd0;
        end
        key_wr_ptr = 9'd0;
        ks_i = 8'd0;
        ks_j = 8'd0;
        key_len_cfg = KEY_LEN_RESET;
        key_filled = 0;
        mismatch_cnt = 0;
        items_sent = 0;
        idle_en = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_key_store_full();
        test_random_traffic(RANDOM_ITEMS);
        // closing stretch runs back to back
        idle_en = 1'b0;
        test_random_traffic(TOTAL_ITEMS);

        release_cmd();
        drain();
        repeat (32) @(posedge i_clk);
        if (mismatch_cnt == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(100_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ rc4_stream_cipher.f @@
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_useq.sv
hw/rtl/rc4_stream_cipher.sv
tb/rc4_stream_cipher_tb.sv
